/* rtl/core/dss_pkg.sv */
package dss_pkg;

   // Field and datapath widths
   localparam int SAMPLE_W     = 16;
   localparam int COL_W        = 12;
   localparam int ROW_W        = 16;
   localparam int WIDTH_REG_W  = 13;
   localparam int GAIN_W       = 32;
   localparam int DIFF_W       = 19;
   localparam int MAG_W        = 18;
   localparam int PROD_W       = 50;
   localparam int NORM_W       = 30;
   localparam int SHIFT_W      = 5;
   localparam int RAD_W        = 62;
   localparam int ROOT_W       = 31;
   localparam int REM_W        = 34;
   localparam int CORDIC_W     = 36;
   localparam int ANGLE_W      = 25;
   localparam int STEP_W       = 5;
   localparam int CORDIC_STEPS = 20;
   localparam int SLOPE_W      = 15;
   localparam int SLOPE_MAX    = 23040;
   localparam int LINE_DEPTH   = 4096;
   localparam int ADDR_W       = 12;
   localparam int UNIT_POS     = 24;
   localparam int PRE_LIMIT    = 29;
   localparam int CSR_IDX_W    = 2;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_X_GAIN       = 2'd2,
      CSR_Y_GAIN       = 2'd3
   } csr_index_type;

   // Request to the angle unit
   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
   } angle_req_type;

   // Result of the angle unit
   typedef struct packed {
      logic               done;
      logic [SLOPE_W-1:0] slope;
   } angle_rsp_type;

   // atan(2^-i) in 1/65536 degree
   function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [ANGLE_W-1:0] v;
      unique case (i)
         5'd0:    v = 25'sd2949120;
         5'd1:    v = 25'sd1740967;
         5'd2:    v = 25'sd919879;
         5'd3:    v = 25'sd466945;
         5'd4:    v = 25'sd234379;
         5'd5:    v = 25'sd117304;
         5'd6:    v = 25'sd58666;
         5'd7:    v = 25'sd29335;
         5'd8:    v = 25'sd14668;
         5'd9:    v = 25'sd7334;
         5'd10:   v = 25'sd3667;
         5'd11:   v = 25'sd1833;
         5'd12:   v = 25'sd917;
         5'd13:   v = 25'sd458;
         5'd14:   v = 25'sd229;
         5'd15:   v = 25'sd115;
         5'd16:   v = 25'sd57;
         5'd17:   v = 25'sd29;
         5'd18:   v = 25'sd14;
         5'd19:   v = 25'sd7;
         default: v = 25'sd0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/core/dem_slope_3x3_core.sv */
// Horn slope of a 16-bit elevation raster, streamed in raster order. Each
// accepted sample reads the two earlier rows from two line memories at its
// column (a registered read), updates a 3x3 window and writes the rows
// back. Border cells give no result. Each interior cell then runs an
// iterative angle unit: two gain products, a normalizing shift, two
// squares, a bit-serial square root, prescaling and 20 CORDIC steps
// (prescaling and the steps are skipped when both differences are zero).
// The next sample waits until the result register can take the result;
// the angle unit sets the rate. The result register lets the next sample
// enter while a result waits. Configuration is written only while the
// block is idle, and a pending write goes ahead of a sample.
module dem_slope_3x3_core (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // elevation[15:0]
   input  logic                                req_tuser,  // frame_start
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // slope_deg[14:0], center_row[30:15], center_col[42:31], zero pad [47:43]
   output logic [47:0]                         rsp_tdata,
   output logic                                rsp_tlast,  // frame_last
   // Configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CALC = 4'b0100,
      S_HOLD = 4'b1000
   } state_type;

   state_type                              state_ff, state_in;
   logic [dss_pkg::WIDTH_REG_W-1:0]        width_ff;
   logic [dss_pkg::ROW_W-1:0]              height_ff;
   logic [dss_pkg::GAIN_W-1:0]             x_gain_ff, y_gain_ff;
   logic [dss_pkg::COL_W-1:0]              col_ff, col_in;
   logic [dss_pkg::ROW_W-1:0]              row_ff, row_in;
   logic [dss_pkg::COL_W-1:0]              item_col_ff;
   logic [dss_pkg::ROW_W-1:0]              item_row_ff;
   logic                                   item_emit_ff, item_last_ff;
   logic [dss_pkg::SAMPLE_W-1:0]           sample_ff;
   logic signed [dss_pkg::SAMPLE_W-1:0]    win_ff [9];
   logic signed [dss_pkg::SAMPLE_W-1:0]    win_in [9];
   logic [dss_pkg::SLOPE_W-1:0]            slope_ff;
   logic                                   rsp_valid_ff;
   logic [dss_pkg::SLOPE_W-1:0]            rsp_slope_ff;
   logic [dss_pkg::ROW_W-1:0]              rsp_row_ff;
   logic [dss_pkg::COL_W-1:0]              rsp_col_ff;
   logic                                   rsp_last_ff;

   logic                                   accept;
   logic [dss_pkg::WIDTH_REG_W-1:0]        w_eff;
   logic [dss_pkg::ROW_W-1:0]              h_eff;
   logic [dss_pkg::COL_W-1:0]              c_cur;
   logic [dss_pkg::ROW_W-1:0]              r_cur;
   logic [dss_pkg::WIDTH_REG_W-1:0]        c_wide;
   logic [dss_pkg::WIDTH_REG_W-1:0]        c_next;
   logic                                   emit_cur, last_cur;
   logic [dss_pkg::SAMPLE_W-1:0]           upper_rd, middle_rd;
   logic signed [dss_pkg::DIFF_W-1:0]      dx, dy;
   logic                                   rsp_free;
   dss_pkg::angle_req_type                 ang_req;
   dss_pkg::angle_rsp_type                 ang_rsp;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dss_pkg::WIDTH_REG_W'(4096);
         height_ff <= dss_pkg::ROW_W'(3);
         x_gain_ff <= dss_pkg::GAIN_W'(2097152);
         y_gain_ff <= dss_pkg::GAIN_W'(2097152);
      end else if (csr_valid && csr_ready) begin
         unique case (dss_pkg::csr_index_type'(csr_index))
            dss_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[dss_pkg::WIDTH_REG_W-1:0];
            dss_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[dss_pkg::ROW_W-1:0];
            dss_pkg::CSR_X_GAIN:       x_gain_ff <= csr_wdata;
            dss_pkg::CSR_Y_GAIN:       y_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective raster size, clamped to the supported range.
   always_comb begin
      if (width_ff < dss_pkg::WIDTH_REG_W'(3)) w_eff = dss_pkg::WIDTH_REG_W'(3);
      else if (width_ff > dss_pkg::WIDTH_REG_W'(dss_pkg::LINE_DEPTH))
         w_eff = dss_pkg::WIDTH_REG_W'(dss_pkg::LINE_DEPTH);
      else w_eff = width_ff;
      h_eff = (height_ff < dss_pkg::ROW_W'(3)) ? dss_pkg::ROW_W'(3) : height_ff;
   end

   // Position of the incoming sample and the position after it.
   always_comb begin
      c_cur    = req_tuser ? '0 : col_ff;
      r_cur    = req_tuser ? '0 : row_ff;
      c_wide   = {1'b0, c_cur};
      c_next   = c_wide + 1'b1;
      emit_cur = (r_cur >= dss_pkg::ROW_W'(2)) && (r_cur <= h_eff - 1'b1) &&
                 (c_wide >= dss_pkg::WIDTH_REG_W'(2)) && (c_wide <= w_eff - 1'b1);
      last_cur = (r_cur == h_eff - 1'b1) && (c_wide == w_eff - 1'b1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (c_next >= w_eff) begin
            col_in = '0;
            row_in = (r_cur == '1) ? r_cur : r_cur + 1'b1;
         end else begin
            col_in = c_next[dss_pkg::COL_W-1:0];
            row_in = r_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Hold the accepted item while the line memories answer.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_col_ff  <= c_cur;
         item_row_ff  <= r_cur;
         item_emit_ff <= emit_cur;
         item_last_ff <= last_cur;
         sample_ff    <= req_tdata;
      end
   end

   dss_line_buf u_line_buf (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (c_cur),
      .wr_en     (state_ff == S_READ),
      .wr_addr   (item_col_ff),
      .wr_sample (sample_ff),
      .upper_rd  (upper_rd),
      .middle_rd (middle_rd)
   );

   // Slide the window one column and bring in the new column.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]     = win_ff[k*3+1];
         win_in[k*3 + 1] = win_ff[k*3+2];
      end
      win_in[2] = upper_rd;
      win_in[5] = middle_rd;
      win_in[8] = sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
      end else if (state_ff == S_READ) begin
         for (int k = 0; k < 9; k++) win_ff[k] <= win_in[k];
      end
   end

   // Weighted (1,2,1) column and row differences.
   assign dx = (dss_pkg::DIFF_W'(win_in[6]) + (dss_pkg::DIFF_W'(win_in[3]) <<< 1) +
                dss_pkg::DIFF_W'(win_in[0])) -
               (dss_pkg::DIFF_W'(win_in[8]) + (dss_pkg::DIFF_W'(win_in[5]) <<< 1) +
                dss_pkg::DIFF_W'(win_in[2]));
   assign dy = (dss_pkg::DIFF_W'(win_in[8]) + (dss_pkg::DIFF_W'(win_in[7]) <<< 1) +
                dss_pkg::DIFF_W'(win_in[6])) -
               (dss_pkg::DIFF_W'(win_in[2]) + (dss_pkg::DIFF_W'(win_in[1]) <<< 1) +
                dss_pkg::DIFF_W'(win_in[0]));

   assign ang_req.start = (state_ff == S_READ) && item_emit_ff;
   assign ang_req.dx    = dx;
   assign ang_req.dy    = dy;

   dss_angle u_angle (
      .clock  (clock),
      .reset  (reset),
      .req    (ang_req),
      .x_gain (x_gain_ff),
      .y_gain (y_gain_ff),
      .rsp    (ang_rsp)
   );

   // Item sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_READ;
         S_READ: state_in = item_emit_ff ? S_CALC : S_IDLE;
         S_CALC: if (ang_rsp.done) state_in = S_HOLD;
         S_HOLD: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CALC && ang_rsp.done) slope_ff <= ang_rsp.slope;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_HOLD && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_HOLD && rsp_free) begin
         rsp_slope_ff <= slope_ff;
         rsp_row_ff   <= item_row_ff - 1'b1;
         rsp_col_ff   <= item_col_ff - 1'b1;
         rsp_last_ff  <= item_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_col_ff, rsp_row_ff, rsp_slope_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/core/dss_line_buf.sv */
module dss_line_buf (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [dss_pkg::ADDR_W-1:0]       rd_addr,
   input  logic                             wr_en,
   input  logic [dss_pkg::ADDR_W-1:0]       wr_addr,
   input  logic [dss_pkg::SAMPLE_W-1:0]     wr_sample,
   output logic [dss_pkg::SAMPLE_W-1:0]     upper_rd,
   output logic [dss_pkg::SAMPLE_W-1:0]     middle_rd
);

   logic [dss_pkg::SAMPLE_W-1:0] upper_mem  [dss_pkg::LINE_DEPTH];
   logic [dss_pkg::SAMPLE_W-1:0] middle_mem [dss_pkg::LINE_DEPTH];

   // Registered read of both lines at the current column.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         upper_rd  <= upper_mem[rd_addr];
         middle_rd <= middle_mem[rd_addr];
      end
   end

   // Rows move up by one: the middle entry just read becomes the upper one.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= middle_rd;
         middle_mem[wr_addr] <= wr_sample;
      end
   end

endmodule

/* rtl/core/dss_angle.sv */
module dss_angle (
   input  logic                              clock,
   input  logic                              reset,
   input  dss_pkg::angle_req_type            req,
   input  logic [dss_pkg::GAIN_W-1:0]        x_gain,
   input  logic [dss_pkg::GAIN_W-1:0]        y_gain,
   output dss_pkg::angle_rsp_type            rsp
);

   typedef enum logic [9:0] {
      A_IDLE = 10'b0000000001,
      A_MULA = 10'b0000000010,
      A_MULB = 10'b0000000100,
      A_NORM = 10'b0000001000,
      A_SQA  = 10'b0000010000,
      A_SQB  = 10'b0000100000,
      A_ROOT = 10'b0001000000,
      A_PRE  = 10'b0010000000,
      A_ROT  = 10'b0100000000,
      A_FIN  = 10'b1000000000
   } astate_type;

   astate_type                              state_ff, state_in;
   logic [dss_pkg::MAG_W-1:0]               mag_x_ff, mag_y_ff;
   logic [dss_pkg::PROD_W-1:0]              a_ff, b_ff;
   logic [dss_pkg::SHIFT_W-1:0]             s_ff;
   logic [dss_pkg::RAD_W-1:0]               rad_ff;
   logic [dss_pkg::REM_W-1:0]               rem_ff;
   logic [dss_pkg::ROOT_W-1:0]              root_ff;
   logic [dss_pkg::STEP_W-1:0]              step_ff;
   logic signed [dss_pkg::CORDIC_W-1:0]     x_ff, y_ff;
   logic signed [dss_pkg::ANGLE_W-1:0]      z_ff;
   logic [dss_pkg::SLOPE_W-1:0]             slope_ff;
   logic                                    done_ff;

   logic [dss_pkg::REM_W-1:0]               rem_try;
   logic [dss_pkg::REM_W-1:0]               trial;
   logic signed [dss_pkg::CORDIC_W-1:0]     xs, ys;
   logic signed [dss_pkg::ANGLE_W-1:0]      z_round;
   logic signed [dss_pkg::ANGLE_W-1:0]      q;
   logic [dss_pkg::SLOPE_W-1:0]             slope_fin;

   // One bit of the square root per cycle.
   assign rem_try = {rem_ff[dss_pkg::REM_W-3:0], rad_ff[dss_pkg::RAD_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};

   // Rotation shifts round toward minus infinity.
   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;

   // Round to 1/256 degree and saturate.
   assign z_round = z_ff + dss_pkg::ANGLE_W'(128);
   assign q       = z_round >>> 8;
   always_comb begin
      if (z_ff <= 0) begin
         slope_fin = '0;
      end else if (q > dss_pkg::ANGLE_W'(dss_pkg::SLOPE_MAX)) begin
         slope_fin = dss_pkg::SLOPE_W'(dss_pkg::SLOPE_MAX);
      end else begin
         slope_fin = q[dss_pkg::SLOPE_W-1:0];
      end
   end

   // Sequencer state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         A_IDLE: if (req.start) state_in = A_MULA;
         A_MULA: state_in = A_MULB;
         A_MULB: state_in = A_NORM;
         A_NORM: begin
            if (a_ff[dss_pkg::PROD_W-1:dss_pkg::NORM_W] == '0 &&
                b_ff[dss_pkg::PROD_W-1:dss_pkg::NORM_W] == '0) state_in = A_SQA;
         end
         A_SQA:  state_in = A_SQB;
         A_SQB:  state_in = A_ROOT;
         A_ROOT: begin
            if (step_ff == dss_pkg::STEP_W'(dss_pkg::ROOT_W - 1)) begin
               if (rem_try >= trial || root_ff != '0) state_in = A_PRE;
               else state_in = A_IDLE;
            end
         end
         A_PRE: begin
            if (!(x_ff < (dss_pkg::CORDIC_W'(1) <<< dss_pkg::PRE_LIMIT) &&
                  y_ff < (dss_pkg::CORDIC_W'(1) <<< dss_pkg::PRE_LIMIT))) state_in = A_ROT;
         end
         A_ROT: begin
            if (step_ff == dss_pkg::STEP_W'(dss_pkg::CORDIC_STEPS - 1)) state_in = A_FIN;
         end
         A_FIN:  state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == A_FIN) ||
                     (state_ff == A_ROOT && state_in == A_IDLE);
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         A_IDLE: begin
            mag_x_ff <= req.dx[dss_pkg::DIFF_W-1] ? dss_pkg::MAG_W'(-req.dx)
                                                 : dss_pkg::MAG_W'(req.dx);
            mag_y_ff <= req.dy[dss_pkg::DIFF_W-1] ? dss_pkg::MAG_W'(-req.dy)
                                                 : dss_pkg::MAG_W'(req.dy);
            s_ff     <= '0;
         end
         A_MULA: a_ff <= dss_pkg::PROD_W'(mag_x_ff * x_gain);
         A_MULB: b_ff <= dss_pkg::PROD_W'(mag_y_ff * y_gain);
         A_NORM: begin
            if (state_in == A_NORM) begin
               a_ff <= a_ff >> 1;
               b_ff <= b_ff >> 1;
               s_ff <= s_ff + 1'b1;
            end
         end
         A_SQA: begin
            rad_ff <= dss_pkg::RAD_W'(a_ff[dss_pkg::NORM_W-1:0] * a_ff[dss_pkg::NORM_W-1:0]);
         end
         A_SQB: begin
            rad_ff  <= rad_ff +
                       dss_pkg::RAD_W'(b_ff[dss_pkg::NORM_W-1:0] * b_ff[dss_pkg::NORM_W-1:0]);
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= '0;
         end
         A_ROOT: begin
            rad_ff  <= rad_ff << 2;
            step_ff <= step_ff + 1'b1;
            if (rem_try >= trial) begin
               rem_ff  <= rem_try - trial;
               root_ff <= {root_ff[dss_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_try;
               root_ff <= {root_ff[dss_pkg::ROOT_W-2:0], 1'b0};
            end
            // Start vectoring from (one, m); a zero root ends with no angle.
            x_ff     <= (dss_pkg::CORDIC_W'(1) <<< dss_pkg::UNIT_POS) >>> s_ff;
            y_ff     <= dss_pkg::CORDIC_W'({root_ff[dss_pkg::ROOT_W-2:0],
                                             (rem_try >= trial)});
            slope_ff <= '0;
         end
         A_PRE: begin
            step_ff <= '0;
            z_ff    <= '0;
            if (state_in == A_PRE) begin
               x_ff <= x_ff <<< 1;
               y_ff <= y_ff <<< 1;
            end
         end
         A_ROT: begin
            step_ff <= step_ff + 1'b1;
            if (y_ff > 0) begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + dss_pkg::atan_entry(step_ff);
            end else begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - dss_pkg::atan_entry(step_ff);
            end
         end
         A_FIN: slope_ff <= slope_fin;
         default: ;
      endcase
   end

   assign rsp.done  = done_ff;
   assign rsp.slope = slope_ff;

endmodule
